>>> hdl/peltier_thermostat_with_cooldown_defines.svh
// Assertion macros shared by the thermostat checker.
// Needs signals named clk and rst in the scope where a macro is used.
`ifndef PELTIER_THERMOSTAT_WITH_COOLDOWN_DEFINES_SVH
`define PELTIER_THERMOSTAT_WITH_COOLDOWN_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("thermostat check failed");

// Next-cycle implication, disabled during reset
`define PTC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thermostat check failed");

`endif

>>> hdl/ptc_pkg.sv
// Shared types, widths and codes for the Peltier thermostat.
// No dependencies.
`default_nettype none

package ptc_pkg;

  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 16;
  localparam int TOL_W   = 14;
  localparam int PWM_W   = 8;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;
  // Thresholds carry two extra bits so target +/- tolerance never wraps
  localparam int THR_W   = TEMP_W + 2;

  // Stop band around the target: 0.10 degree in hundredths
  localparam logic [THR_W-1:0] STOP_BAND = THR_W'(10);
  localparam logic [PWM_W-1:0] FAN_FULL  = PWM_W'(255);

  // Reset values of the configuration registers
  localparam logic signed [TEMP_W-1:0] TARGET_RST   = TEMP_W'(2500);
  localparam logic [TOL_W-1:0]         TOL_RST      = TOL_W'(100);
  localparam logic [TIME_W-1:0]        COOLDOWN_RST = TIME_W'(30000);
  localparam logic [PWM_W-1:0]         MAIN_FAN_RST = PWM_W'(255);
  localparam logic [PWM_W-1:0]         AUX_FAN_RST  = PWM_W'(255);

  typedef enum logic [CIDX_W-1:0] {
    CFG_TARGET_TEMP = 3'd0,
    CFG_TOLERANCE   = 3'd1,
    CFG_COOLDOWN    = 3'd2,
    CFG_MAIN_FAN    = 3'd3,
    CFG_AUX_FAN     = 3'd4
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HEAT  = 2'd1,
    MODE_COOL  = 2'd2,
    MODE_DELAY = 2'd3
  } mode_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] target_temp;
    logic [TOL_W-1:0]         tolerance;
    logic [TIME_W-1:0]        cooldown_ms;
    logic [PWM_W-1:0]         main_fan_speed;
    logic [PWM_W-1:0]         aux_fan_speed;
  } cfg_t;

  typedef struct packed {
    logic             heat_on;
    logic             cool_on;
    logic [PWM_W-1:0] fan_pwm;
    logic [PWM_W-1:0] aux_fan_pwm;
    mode_t            mode;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ptc_cfg_regs.sv
// Configuration register file for the thermostat.
// Depends on ptc_pkg.
`default_nettype none

module ptc_cfg_regs import ptc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data,
  output cfg_t                    cfg
);

  // Register writes, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_temp    <= TARGET_RST;
      cfg.tolerance      <= TOL_RST;
      cfg.cooldown_ms    <= COOLDOWN_RST;
      cfg.main_fan_speed <= MAIN_FAN_RST;
      cfg.aux_fan_speed  <= AUX_FAN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TARGET_TEMP: cfg.target_temp    <= $signed(cfg_data[TEMP_W-1:0]);
        CFG_TOLERANCE:   cfg.tolerance      <= cfg_data[TOL_W-1:0];
        CFG_COOLDOWN:    cfg.cooldown_ms    <= cfg_data[TIME_W-1:0];
        CFG_MAIN_FAN:    cfg.main_fan_speed <= cfg_data[PWM_W-1:0];
        CFG_AUX_FAN:     cfg.aux_fan_speed  <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/ptc_ctrl.sv
// Thermostat control state and the per-tick decision logic.
// Depends on ptc_pkg.
`default_nettype none

module ptc_ctrl import ptc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic [TIME_W-1:0]        now_ms,
  input  wire logic signed [TEMP_W-1:0] current_temp,
  input  wire cfg_t                     cfg,
  output result_t                       res
);

  logic              heating, cooling, in_delay;
  logic [TIME_W-1:0] last_cool_switch, last_heat_switch;

  logic              heating_next, cooling_next, in_delay_next;
  logic [TIME_W-1:0] last_cool_switch_next, last_heat_switch_next;

  logic [TIME_W-1:0]       since_cool, since_heat;
  logic                    cool_young, heat_young, hold;
  logic signed [THR_W-1:0] temp_x, tgt_x, tol_x;
  logic signed [THR_W-1:0] heat_start_thr, cool_start_thr, heat_stop_thr, cool_stop_thr;
  logic                    want_heat, want_cool, stop_heat, stop_cool;
  logic                    heat_keep, cool_keep, start_heat, start_cool;
  logic                    cool_young_after, heat_young_after, fans_run, active;

  // Age of the last switches; both compares serve the delay check and the fans
  assign since_cool = now_ms - last_cool_switch;
  assign since_heat = now_ms - last_heat_switch;
  assign cool_young = since_cool < cfg.cooldown_ms;
  assign heat_young = since_heat < cfg.cooldown_ms;
  assign hold       = in_delay && (cool_young || heat_young);

  // Thresholds in widened signed arithmetic
  assign temp_x = THR_W'(current_temp);
  assign tgt_x  = THR_W'(cfg.target_temp);
  assign tol_x  = $signed({{(THR_W-TOL_W){1'b0}}, cfg.tolerance});
  assign heat_start_thr = tgt_x - tol_x;
  assign cool_start_thr = tgt_x + tol_x;
  assign heat_stop_thr  = tgt_x - $signed(STOP_BAND);
  assign cool_stop_thr  = tgt_x + $signed(STOP_BAND);

  assign want_heat = temp_x < heat_start_thr;
  assign want_cool = temp_x > cool_start_thr;

  // Stop near the target, heating has priority
  assign stop_heat = heating && (temp_x >= heat_stop_thr);
  assign stop_cool = !stop_heat && cooling && (temp_x <= cool_stop_thr);
  assign heat_keep = heating && !stop_heat;
  assign cool_keep = cooling && !stop_cool;

  // Start only from a state with no mode running
  assign start_heat = want_heat && !heat_keep && !cool_keep;
  assign start_cool = !start_heat && want_cool && !heat_keep && !cool_keep;

  // Next state
  always_comb begin
    heating_next          = heating;
    cooling_next          = cooling;
    in_delay_next         = in_delay;
    last_cool_switch_next = last_cool_switch;
    last_heat_switch_next = last_heat_switch;
    if (!hold) begin
      heating_next  = heat_keep || start_heat;
      cooling_next  = cool_keep || start_cool;
      in_delay_next = (stop_heat || stop_cool) && !start_heat && !start_cool;
      if (stop_heat || start_heat) last_heat_switch_next = now_ms;
      if (stop_cool || start_cool) last_cool_switch_next = now_ms;
    end
  end

  // A switch this tick makes its age zero: young unless cooldown is zero
  assign cool_young_after = (stop_cool || start_cool) ? (cfg.cooldown_ms != '0) : cool_young;
  assign heat_young_after = (stop_heat || start_heat) ? (cfg.cooldown_ms != '0) : heat_young;
  assign active   = heating_next || cooling_next;
  assign fans_run = active || cool_young_after || heat_young_after;

  // Result of this tick
  always_comb begin
    if (hold) begin
      res.heat_on     = 1'b0;
      res.cool_on     = 1'b0;
      res.fan_pwm     = FAN_FULL;
      res.aux_fan_pwm = '0;
      res.mode        = MODE_DELAY;
    end else begin
      res.heat_on     = heating_next;
      res.cool_on     = cooling_next;
      res.fan_pwm     = fans_run ? cfg.main_fan_speed : '0;
      res.aux_fan_pwm = active ? cfg.aux_fan_speed : '0;
      res.mode        = heating_next ? MODE_HEAT : (cooling_next ? MODE_COOL : MODE_IDLE);
    end
  end

  // State update on each tick that moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      heating          <= 1'b0;
      cooling          <= 1'b0;
      in_delay         <= 1'b1;
      last_cool_switch <= '0;
      last_heat_switch <= '0;
    end else if (step) begin
      heating          <= heating_next;
      cooling          <= cooling_next;
      in_delay         <= in_delay_next;
      last_cool_switch <= last_cool_switch_next;
      last_heat_switch <= last_heat_switch_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/peltier_thermostat_with_cooldown.sv
// Top level of the Peltier thermostat: input register, control, result register.
// Depends on ptc_pkg, ptc_cfg_regs and ptc_ctrl.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------------
//   input    | in_valid / in_ready        | now_ms, current_temp
//   output   | out_valid / out_ready      | heat_on, cool_on, fan_pwm, aux_fan_pwm, mode
//   config   | cfg_we (no wait)           | cfg_index, cfg_data
//
// One request per cycle unless stalled; each passes input, then result register.
// The decision path is one 32-bit subtract and compare against the cooldown.
// Reset clears the mode flags and switch times and starts in the cooldown delay.
// A stalled output holds its result; the input register still takes one request.
`default_nettype none

module peltier_thermostat_with_cooldown import ptc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [TIME_W-1:0]        now_ms,
  input  wire logic signed [TEMP_W-1:0] current_temp,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          heat_on,
  output logic                          cool_on,
  output logic [PWM_W-1:0]              fan_pwm,
  output logic [PWM_W-1:0]              aux_fan_pwm,
  output logic [MODE_W-1:0]             mode,
  input  wire logic                     cfg_we,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CDATA_W-1:0]       cfg_data
);

  cfg_t    cfg;
  result_t res;

  logic                     s1_valid;
  logic [TIME_W-1:0]        s1_now;
  logic signed [TEMP_W-1:0] s1_temp;
  logic                     out_free, step;

  ptc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ptc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .now_ms       (s1_now),
    .current_temp (s1_temp),
    .cfg          (cfg),
    .res          (res)
  );

  // Flow control between input register and result register
  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_now  <= now_ms;
      s1_temp <= current_temp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      heat_on     <= res.heat_on;
      cool_on     <= res.cool_on;
      fan_pwm     <= res.fan_pwm;
      aux_fan_pwm <= res.aux_fan_pwm;
      mode        <= res.mode;
    end
  end

endmodule

`default_nettype wire

>>> hdl/ptc_checker.sv
// Port-level checks for the thermostat, bound to the top level.
// Depends on ptc_pkg and peltier_thermostat_with_cooldown_defines.svh.
`default_nettype none
`include "peltier_thermostat_with_cooldown_defines.svh"

module ptc_checker import ptc_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic                     heat_on,
  input wire logic                     cool_on,
  input wire logic [PWM_W-1:0]         fan_pwm,
  input wire logic [PWM_W-1:0]         aux_fan_pwm,
  input wire logic [MODE_W-1:0]        mode
);

  logic delay_outputs_ok, drive_matches_mode;

  assign delay_outputs_ok   = !heat_on && !cool_on && (fan_pwm == FAN_FULL) &&
                              (aux_fan_pwm == '0);
  assign drive_matches_mode = (heat_on == (mode == MODE_HEAT)) &&
                              (cool_on == (mode == MODE_COOL));

  // Delay results drive the fan full with the Peltier and small fan off
  `PTC_ASSERT_IMP(a_delay_out, out_valid && (mode == MODE_DELAY), delay_outputs_ok)

  // Drive bits agree with the reported mode
  `PTC_ASSERT_IMP(a_mode_drive, out_valid, drive_matches_mode)

  // Small fan runs only while the Peltier is driven
  `PTC_ASSERT_IMP(a_aux_fan, out_valid && (aux_fan_pwm != '0), heat_on || cool_on)

  // A stalled result stays put
  `PTC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(fan_pwm))

endmodule

bind peltier_thermostat_with_cooldown ptc_checker u_ptc_checker (.*);

`default_nettype wire
